>>> rtl/core/ilir_pkg.sv
package ilir_pkg;

	localparam int DATA_W   = 32;
	localparam int POS_W    = 7;
	localparam int LEN_W    = 7;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	// Cells per group of the read-out tree.
	localparam int GRP_SIZE = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_GET    = 2'd2,
		CMD_SET    = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_LEFT,
		MODE_RIGHT,
		MODE_LOAD
	} cell_mode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESULT
	} state_t;

endpackage

>>> rtl/core/ilir_in_if.sv
interface ilir_in_if;
	logic                               valid;
	logic                               ready;
	logic [ilir_pkg::CMD_W-1:0]         cmd;
	logic [ilir_pkg::POS_W-1:0]         position;
	logic signed [ilir_pkg::DATA_W-1:0] value_in;

	modport source (output valid, output cmd, output position, output value_in, input ready);
	modport sink (input valid, input cmd, input position, input value_in, output ready);
endinterface

>>> rtl/core/ilir_out_if.sv
interface ilir_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [ilir_pkg::DATA_W-1:0] value_out;
	logic [ilir_pkg::STATUS_W-1:0]      status;
	logic [ilir_pkg::LEN_W-1:0]         length;

	modport source (output valid, output value_out, output status, output length, input ready);
	modport sink (input valid, input value_out, input status, input length, output ready);
endinterface

>>> rtl/core/ilir_cell.sv
module ilir_cell (
	input  logic                          clk,
	input  ilir_pkg::cell_mode_t          mode,
	input  logic [ilir_pkg::DATA_W-1:0]   left,
	input  logic [ilir_pkg::DATA_W-1:0]   right,
	input  logic [ilir_pkg::DATA_W-1:0]   load,
	input  logic                          sel,
	output logic [ilir_pkg::DATA_W-1:0]   data,
	output logic [ilir_pkg::DATA_W-1:0]   rd
);

	logic [ilir_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (mode)
			ilir_pkg::MODE_LEFT:  data_q <= left;
			ilir_pkg::MODE_RIGHT: data_q <= right;
			ilir_pkg::MODE_LOAD:  data_q <= load;
			default:              data_q <= data_q;
		endcase
	end

	assign data = data_q;
	// Only the addressed cell drives the read-out tree.
	assign rd = sel ? data_q : '0;

endmodule

>>> rtl/core/indexed_list_insert_remove_core.sv
// A command is registered when accepted, executed in S_EXEC, and its result is loaded into the
// output register from S_RESULT; a new command is accepted only in S_IDLE, once that is done.
// The cell row updates at the end of S_EXEC, and the addressed entry comes out through a
// two-level registered OR tree.
// A waiting result does not block the next command; only loading the next result waits for it.
// Reset clears the entry count, the sequencer and the output valid; entries are not cleared.
module indexed_list_insert_remove_core #(
	parameter int CAPACITY = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	ilir_in_if.sink      in,
	ilir_out_if.source   out
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > ilir_pkg::POS_W) ? CNT_W : ilir_pkg::POS_W;
	localparam int NGRP  = (CAPACITY + ilir_pkg::GRP_SIZE - 1) / ilir_pkg::GRP_SIZE;
	localparam int DW    = ilir_pkg::DATA_W;

	ilir_pkg::state_t  state_q, state_d;
	ilir_pkg::cmd_t    cmd_q;
	logic [ilir_pkg::POS_W-1:0] pos_q;
	logic [DW-1:0]     val_q;
	logic [CNT_W-1:0]  count_q;

	ilir_pkg::status_t status_c, status_s2;
	logic              rdok_s2;
	logic [DW-1:0]     grp_c  [NGRP];
	logic [DW-1:0]     grp_s2 [NGRP];
	logic [DW-1:0]     rd_val;

	logic              out_valid_q;
	logic [DW-1:0]     out_value_q;
	ilir_pkg::status_t out_status_q;
	logic [ilir_pkg::LEN_W-1:0] out_length_q;

	logic accept, exec, result_ld;
	logic [CMP_W-1:0] pos_ext, cnt_ext;
	logic op_ok;

	logic [DW-1:0] cell_data [CAPACITY];
	logic [DW-1:0] cell_rd   [CAPACITY];

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ilir_pkg::S_IDLE:   if (in.valid) state_d = ilir_pkg::S_EXEC;
			ilir_pkg::S_EXEC:   state_d = ilir_pkg::S_RESULT;
			ilir_pkg::S_RESULT: if (!out_valid_q || out.ready) state_d = ilir_pkg::S_IDLE;
			default:            state_d = ilir_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in.ready  = 1'b0;
		exec      = 1'b0;
		result_ld = 1'b0;
		case (state_q)
			ilir_pkg::S_IDLE:   in.ready = 1'b1;
			ilir_pkg::S_EXEC:   exec = 1'b1;
			ilir_pkg::S_RESULT: result_ld = !out_valid_q || out.ready;
			default: begin
				in.ready  = 1'b0;
				exec      = 1'b0;
				result_ld = 1'b0;
			end
		endcase
	end

	assign accept = in.valid && in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilir_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= ilir_pkg::cmd_t'(in.cmd);
			pos_q <= in.position;
			val_q <= in.value_in;
		end
	end

	// Command check against the current count.
	assign pos_ext = CMP_W'(pos_q);
	assign cnt_ext = CMP_W'(count_q);

	always_comb begin
		status_c = ilir_pkg::ST_OK;
		if (cmd_q == ilir_pkg::CMD_ADD) begin
			if (pos_ext > cnt_ext) begin
				status_c = ilir_pkg::ST_RANGE;
			end else if (cnt_ext == CMP_W'(CAPACITY)) begin
				status_c = ilir_pkg::ST_FULL;
			end
		end else if (pos_ext >= cnt_ext) begin
			status_c = ilir_pkg::ST_RANGE;
		end
	end

	assign op_ok = exec && (status_c == ilir_pkg::ST_OK);

	// Row of cells: each one holds one list position.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ilir_pkg::cell_mode_t mode;
		logic                 hit;
		logic [DW-1:0]        left, right;

		assign hit = (pos_ext == CMP_W'(i));

		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = cell_data[i];
		end else begin : g_mid_r
			assign right = cell_data[i+1];
		end

		always_comb begin
			mode = ilir_pkg::MODE_HOLD;
			if (op_ok) begin
				case (cmd_q)
					ilir_pkg::CMD_ADD: begin
						if (hit) mode = ilir_pkg::MODE_LOAD;
						else if (pos_ext < CMP_W'(i)) mode = ilir_pkg::MODE_LEFT;
					end
					ilir_pkg::CMD_REMOVE: begin
						if (pos_ext <= CMP_W'(i)) mode = ilir_pkg::MODE_RIGHT;
					end
					ilir_pkg::CMD_SET: begin
						if (hit) mode = ilir_pkg::MODE_LOAD;
					end
					default: mode = ilir_pkg::MODE_HOLD;
				endcase
			end
		end

		ilir_cell u_cell (
			.clk   (clk),
			.mode  (mode),
			.left  (left),
			.right (right),
			.load  (val_q),
			.sel   (hit),
			.data  (cell_data[i]),
			.rd    (cell_rd[i])
		);
	end

	// First level of the read-out tree; it samples the old entries at the update edge.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_c[g] = '0;
			for (int k = 0; k < ilir_pkg::GRP_SIZE; k++) begin
				if (g * ilir_pkg::GRP_SIZE + k < CAPACITY) begin
					grp_c[g] = grp_c[g] | cell_rd[g * ilir_pkg::GRP_SIZE + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			grp_s2    <= grp_c;
			status_s2 <= status_c;
			rdok_s2   <= (status_c == ilir_pkg::ST_OK) && (cmd_q != ilir_pkg::CMD_ADD);
		end
	end

	always_comb begin
		rd_val = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_val = rd_val | grp_s2[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op_ok) begin
			if (cmd_q == ilir_pkg::CMD_ADD) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd_q == ilir_pkg::CMD_REMOVE) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_ld) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_ld) begin
			out_value_q  <= rdok_s2 ? rd_val : '0;
			out_status_q <= status_s2;
			out_length_q <= ilir_pkg::LEN_W'(count_q);
		end
	end

	assign out.valid     = out_valid_q;
	assign out.value_out = out_value_q;
	assign out.status    = out_status_q;
	assign out.length    = out_length_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(CAPACITY) >= count_q)
		else $error("entry count above capacity");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && (out.status != ilir_pkg::ST_OK) |-> out.value_out == '0)
		else $error("error result carries a nonzero value");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ilir_pkg::S_EXEC)
		else $error("accepted command did not start execution");

	a_result_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ilir_pkg::S_EXEC |=> state_q == ilir_pkg::S_RESULT)
		else $error("execution not followed by result stage");

endmodule

>>> tb/sv/tb_indexed_list_insert_remove_core.sv
module tb_indexed_list_insert_remove_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_CAP = 64;
	localparam int STALL_PCT = 21;
	localparam int QUIET_LIMIT = 5000;
	localparam int TAIL_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic signed [ilir_pkg::DATA_W-1:0] value;
		ilir_pkg::status_t                  status;
		logic [ilir_pkg::LEN_W-1:0]         length;
	} list_result_t;

	logic clk;
	logic arst_n;

	ilir_in_if  cmd_ch ();
	ilir_out_if res_ch ();

	indexed_list_insert_remove_core #(
		.CAPACITY(LIST_CAP)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (cmd_ch.sink),
		.out   (res_ch.source)
	);

	// Shadow copy of the list as the block should hold it.
	logic signed [ilir_pkg::DATA_W-1:0] shadow_list [LIST_CAP];
	int                       shadow_len;
	list_result_t             pending_results[$];
	int unsigned              mismatch_count;
	int unsigned              quiet_cycles;
	bit                       calm;

	always #10 clk = ~clk;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		calm = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = ilir_pkg::CMD_GET;
		cmd_ch.position = '0;
		cmd_ch.value_in = '0;
		res_ch.ready = 1'b0;
		shadow_len = 0;
		mismatch_count = 0;
		quiet_cycles = 0;
	end

	function automatic list_result_t apply_command(ilir_pkg::cmd_t op,
			logic [ilir_pkg::POS_W-1:0] pos, logic signed [ilir_pkg::DATA_W-1:0] val);
		list_result_t r;
		int p;
		p = int'(pos);
		r.value = '0;
		r.status = ilir_pkg::ST_OK;
		if (op == ilir_pkg::CMD_ADD) begin
			if (p > shadow_len) begin
				r.status = ilir_pkg::ST_RANGE;
			end else if (shadow_len >= LIST_CAP) begin
				r.status = ilir_pkg::ST_FULL;
			end else begin
				for (int k = shadow_len; k > p; k--)
					shadow_list[k] = shadow_list[k-1];
				shadow_list[p] = val;
				shadow_len++;
			end
		end else if (p >= shadow_len) begin
			r.status = ilir_pkg::ST_RANGE;
		end else begin
			r.value = shadow_list[p];
			case (op)
				ilir_pkg::CMD_REMOVE: begin
					for (int k = p; k + 1 < shadow_len; k++)
						shadow_list[k] = shadow_list[k+1];
					shadow_len--;
				end
				ilir_pkg::CMD_SET: begin
					shadow_list[p] = val;
				end
				default: ;
			endcase
		end
		r.length = shadow_len[ilir_pkg::LEN_W-1:0];
		return r;
	endfunction

	function automatic logic signed [ilir_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return -32'sd1;
			3: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(ilir_pkg::cmd_t op, int pos,
			logic signed [ilir_pkg::DATA_W-1:0] val);
		while (!calm && $urandom_range(99) < STALL_PCT) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.cmd <= op;
		cmd_ch.position <= pos[ilir_pkg::POS_W-1:0];
		cmd_ch.value_in <= val;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		pending_results.push_back(apply_command(op, pos[ilir_pkg::POS_W-1:0], val));
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_list();
		send_word(ilir_pkg::CMD_REMOVE, 0, 32'sd0);
		send_word(ilir_pkg::CMD_GET, 0, 32'sd0);
		send_word(ilir_pkg::CMD_SET, 0, 32'sd5);
		send_word(ilir_pkg::CMD_ADD, 1, 32'sd7);
		send_word(ilir_pkg::CMD_ADD, 64, 32'sd7);
		send_word(ilir_pkg::CMD_GET, 127, 32'sd0);
	endtask

	task automatic test_basic_ops();
		send_word(ilir_pkg::CMD_ADD, 0, 32'sh7fffffff);
		send_word(ilir_pkg::CMD_ADD, 0, 32'sh80000000);
		send_word(ilir_pkg::CMD_ADD, 2, -32'sd1);
		send_word(ilir_pkg::CMD_ADD, 1, 32'sd0);
		send_word(ilir_pkg::CMD_ADD, 5, 32'sd3);
		send_word(ilir_pkg::CMD_GET, 0, 32'sd0);
		send_word(ilir_pkg::CMD_GET, 3, 32'sd0);
		send_word(ilir_pkg::CMD_GET, 4, 32'sd0);
		send_word(ilir_pkg::CMD_SET, 3, 32'sh55555555);
		send_word(ilir_pkg::CMD_SET, 0, 32'shaaaaaaaa);
		send_word(ilir_pkg::CMD_SET, 4, 32'sd1);
		send_word(ilir_pkg::CMD_REMOVE, 1, 32'sd0);
		send_word(ilir_pkg::CMD_REMOVE, 2, 32'sd0);
		send_word(ilir_pkg::CMD_REMOVE, 2, 32'sd0);
		send_word(ilir_pkg::CMD_REMOVE, 0, 32'sd0);
		send_word(ilir_pkg::CMD_REMOVE, 0, 32'sd0);
		send_word(ilir_pkg::CMD_GET, 0, 32'sd0);
	endtask

	task automatic test_full_list();
		// Hold off until the block has nothing in flight.
		wait_drained();
		while (shadow_len < LIST_CAP)
			send_word(ilir_pkg::CMD_ADD, $urandom_range(shadow_len, 0), pick_value());
		send_word(ilir_pkg::CMD_ADD, LIST_CAP, 32'sd9);
		send_word(ilir_pkg::CMD_ADD, 0, 32'sd9);
		send_word(ilir_pkg::CMD_ADD, LIST_CAP + 1, 32'sd9);
		send_word(ilir_pkg::CMD_ADD, 127, 32'sd9);
		send_word(ilir_pkg::CMD_GET, LIST_CAP - 1, 32'sd0);
		send_word(ilir_pkg::CMD_SET, LIST_CAP - 1, 32'sh12345678);
		send_word(ilir_pkg::CMD_GET, LIST_CAP, 32'sd0);
		send_word(ilir_pkg::CMD_REMOVE, LIST_CAP - 1, 32'sd0);
		send_word(ilir_pkg::CMD_ADD, LIST_CAP - 1, 32'sh0badcafe);
		send_word(ilir_pkg::CMD_REMOVE, 0, 32'sd0);
	endtask

	// Mostly well-formed commands that steer the length toward a wandering goal;
	// about one in ten has a random position that is often out of range.
	task automatic random_commands(int n, int lo, int hi);
		int goal;
		int pos;
		int i;
		ilir_pkg::cmd_t op;
		goal = lo;
		for (i = 0; i < n; i++) begin
			if (i % 20 == 0)
				goal = $urandom_range(hi, lo);
			if ($urandom_range(9) == 0) begin
				op = ilir_pkg::cmd_t'($urandom_range(3));
				pos = $urandom_range(127);
			end else begin
				if (shadow_len == 0 ||
						$urandom_range(9) < ((shadow_len < goal) ? 7 : 2)) begin
					op = ilir_pkg::CMD_ADD;
				end else begin
					case ($urandom_range(3))
						0: op = ilir_pkg::CMD_GET;
						1: op = ilir_pkg::CMD_SET;
						default: op = ilir_pkg::CMD_REMOVE;
					endcase
				end
				if (op == ilir_pkg::CMD_ADD)
					pos = $urandom_range(shadow_len, 0);
				else
					pos = $urandom_range(shadow_len - 1, 0);
			end
			send_word(op, pos, pick_value());
		end
	endtask

	task automatic test_random();
		random_commands(75, 40, LIST_CAP);
		random_commands(75, 0, 8);
		calm = 1'b1;
		random_commands(75, 0, LIST_CAP);
		calm = 1'b0;
		random_commands(75, 16, 48);
	endtask

	always @(posedge clk)
		res_ch.ready <= calm || ($urandom_range(99) >= STALL_PCT);

	always @(posedge clk) begin
		list_result_t want;
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
		if (res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count <= mismatch_count + 1;
				if (mismatch_count < MAX_REPORTS)
					$display("unexpected result word: value %0d status %0d length %0d",
						res_ch.value_out, res_ch.status, res_ch.length);
			end else begin
				want = pending_results.pop_front();
				if (res_ch.value_out !== want.value || res_ch.status !== want.status ||
						res_ch.length !== want.length) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < MAX_REPORTS)
						$display("mismatch: expected value %0d status %0d length %0d, got %0d %0d %0d",
							want.value, want.status, want.length,
							res_ch.value_out, res_ch.status, res_ch.length);
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_basic_ops();
		test_full_list();
		test_random();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/ilir_pkg.sv
rtl/core/ilir_in_if.sv
rtl/core/ilir_out_if.sv
rtl/core/ilir_cell.sv
rtl/core/indexed_list_insert_remove_core.sv
tb/sv/tb_indexed_list_insert_remove_core.sv
